// ===== sv/hgrs_pkg.sv =====
// ----------------------------------------------------------------------------
// hgrs_pkg
// Shared types, character codes and helpers for the GET request screener.
// ----------------------------------------------------------------------------
package hgrs_pkg;

  localparam int unsigned POS_BITS   = 16;
  localparam int unsigned WIN_BITS   = 16;
  localparam int unsigned DEPTH_BITS = 16;
  localparam int unsigned LEN_BITS   = 16;

  localparam logic [POS_BITS-1:0]   POS_MAX      = {POS_BITS{1'b1}};
  localparam logic [DEPTH_BITS-1:0] DEPTH_MAX    = {DEPTH_BITS{1'b1}};
  localparam logic [WIN_BITS-1:0]   WINDOW_RESET = WIN_BITS'(8192);
  localparam logic [POS_BITS-1:0]   PREFIX_LAST  = POS_BITS'(4);
  localparam logic [POS_BITS-1:0]   PREFIX_LEN   = POS_BITS'(5);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_G     = 8'h47;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_T     = 8'h54;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  typedef enum logic [3:0] {
    PHASE_PREFIX = 4'b0001,
    PHASE_PATH   = 4'b0010,
    PHASE_SPACE  = 4'b0100,
    PHASE_STOP   = 4'b1000
  } phase_e;

  typedef struct packed {
    logic                verdict;
    logic [LEN_BITS-1:0] path_length;
  } verdict_t;

  // Expected byte of the "GET /" prefix at a given position.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] c;
    case (idx)
      3'd0:    c = CHAR_G;
      3'd1:    c = CHAR_E;
      3'd2:    c = CHAR_T;
      3'd3:    c = CHAR_SPACE;
      3'd4:    c = CHAR_SLASH;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== sv/hgrs_term_match.sv =====
// ----------------------------------------------------------------------------
// hgrs_term_match
// Tracks CR LF CR LF across bytes and flags the byte that completes it.
// ----------------------------------------------------------------------------
module hgrs_term_match
  import hgrs_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       done_o
);

  logic [1:0] prog_q, prog_d;
  logic [7:0] expected;
  logic       match;

  // Even progress expects CR, odd progress expects LF.
  assign expected = prog_q[0] ? CHAR_LF : CHAR_CR;
  assign match    = (byte_i == expected);
  assign done_o   = match && (prog_q == 2'd3);

  always_comb begin
    prog_d = prog_q;
    if (step_i) begin
      if (done_o) begin
        prog_d = 2'd0;
      end else if (match) begin
        prog_d = prog_q + 2'd1;
      end else if (byte_i == CHAR_CR) begin
        // restart on a stray CR with one byte already matched
        prog_d = 2'd1;
      end else begin
        prog_d = 2'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_q <= 2'd0;
    end else begin
      prog_q <= prog_d;
    end
  end

endmodule

// ===== sv/hgrs_path_scan.sv =====
// ----------------------------------------------------------------------------
// hgrs_path_scan
// Checks the request prefix, scans the path depth and forms the verdict.
// ----------------------------------------------------------------------------
module hgrs_path_scan
  import hgrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic                done_i,
  input  logic [7:0]          byte_i,
  input  logic [WIN_BITS-1:0] window_limit_i,
  output verdict_t            verdict_o
);

  logic [POS_BITS-1:0]   pos_q, pos_d;
  logic [POS_BITS-1:0]   end_q, end_d;
  logic [DEPTH_BITS-1:0] depth_q, depth_d;
  logic [7:0]            recent_q [3];
  logic [7:0]            recent_d [3];
  phase_e                phase_q, phase_d;
  logic                  reject_q, reject_d;
  logic                  in_window;
  logic                  dotdot;
  logic [POS_BITS-1:0]   len_full;

  assign in_window = (32'(pos_q) < 32'(window_limit_i)) && (pos_q != POS_MAX);
  assign dotdot    = (recent_q[0] == CHAR_DOT) && (recent_q[1] == CHAR_DOT)
                  && (recent_q[2] == CHAR_SLASH);

  // Next state as if this byte were scanned; the verdict reads it directly.
  always_comb begin
    pos_d       = pos_q;
    end_d       = end_q;
    depth_d     = depth_q;
    recent_d[0] = recent_q[0];
    recent_d[1] = recent_q[1];
    recent_d[2] = recent_q[2];
    phase_d     = phase_q;
    reject_d    = reject_q;
    if (in_window) begin
      case (phase_q)
        PHASE_PREFIX: begin
          if (pos_q < PREFIX_LEN && byte_i != prefix_char(pos_q[2:0])) begin
            reject_d = 1'b1;
            phase_d  = PHASE_STOP;
          end else if (pos_q == PREFIX_LAST) begin
            phase_d = PHASE_PATH;
          end
        end
        PHASE_PATH: begin
          if (byte_i == CHAR_SPACE) begin
            phase_d = PHASE_SPACE;
            end_d   = pos_q;
          end else if (byte_i == CHAR_SLASH) begin
            if (dotdot) begin
              if (depth_q == '0) begin
                reject_d = 1'b1;
                phase_d  = PHASE_STOP;
              end else begin
                depth_d = depth_q - DEPTH_BITS'(1);
              end
            end else if (depth_q != DEPTH_MAX) begin
              depth_d = depth_q + DEPTH_BITS'(1);
            end
          end
        end
        default: begin
        end
      endcase
      recent_d[2] = recent_q[1];
      recent_d[1] = recent_q[0];
      recent_d[0] = byte_i;
      pos_d       = pos_q + POS_BITS'(1);
    end
  end

  assign len_full = end_d - PREFIX_LAST;

  always_comb begin
    if (reject_d || phase_d != PHASE_SPACE || end_d < PREFIX_LAST) begin
      verdict_o.verdict     = 1'b1;
      verdict_o.path_length = '0;
    end else begin
      verdict_o.verdict     = 1'b0;
      verdict_o.path_length = LEN_BITS'(len_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      end_q       <= '0;
      depth_q     <= '0;
      recent_q[0] <= '0;
      recent_q[1] <= '0;
      recent_q[2] <= '0;
      phase_q     <= PHASE_PREFIX;
      reject_q    <= 1'b0;
    end else if (step_i) begin
      if (done_i) begin
        // clear for the next request
        pos_q       <= '0;
        end_q       <= '0;
        depth_q     <= '0;
        recent_q[0] <= '0;
        recent_q[1] <= '0;
        recent_q[2] <= '0;
        phase_q     <= PHASE_PREFIX;
        reject_q    <= 1'b0;
      end else begin
        pos_q       <= pos_d;
        end_q       <= end_d;
        depth_q     <= depth_d;
        recent_q[0] <= recent_d[0];
        recent_q[1] <= recent_d[1];
        recent_q[2] <= recent_d[2];
        phase_q     <= phase_d;
        reject_q    <= reject_d;
      end
    end
  end

endmodule

// ===== sv/http_get_request_screener_core.sv =====
// Input bytes are registered in byte_q; verdicts are registered in result_q.
// Throughput: one byte per cycle unless the output stalls; the update of the
// scan state (position, depth, phase) and the terminator matcher sets this rate.
// Reset clears scan, matcher and valid state and loads window_limit with 8192.
// ----------------------------------------------------------------------------
// http_get_request_screener_core
// Screens a byte stream of HTTP requests and gives one verdict per request.
// ----------------------------------------------------------------------------
module http_get_request_screener_core
  import hgrs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [WIN_BITS-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          request_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                verdict_o,
  output logic [LEN_BITS-1:0] path_length_o
);

  logic [WIN_BITS-1:0] window_q;
  logic                in_valid_q;
  logic [7:0]          byte_q;
  logic                out_valid_q;
  verdict_t            result_q;
  verdict_t            result;
  logic                out_free;
  logic                step;
  logic                done;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign step       = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  hgrs_term_match u_term (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (byte_q),
    .done_o (done)
  );

  hgrs_path_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .done_i         (done),
    .byte_i         (byte_q),
    .window_limit_i (window_q),
    .verdict_o      (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= WINDOW_RESET;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (!in_stall_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step && done;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      byte_q <= request_byte_i;
    end
    if (step && done) begin
      result_q <= result;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign verdict_o     = result_q.verdict;
  assign path_length_o = result_q.path_length;

`ifndef SYNTHESIS
  a_reject_zero_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && verdict_o |-> path_length_o == '0)
    else $error("rejected request carries a nonzero path length");

  a_hold_input : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while a byte waits on a stalled result");

  a_done_on_lf : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done |-> byte_q == CHAR_LF)
    else $error("terminator completed on a byte other than LF");

  a_result_follows_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(step && done))
    else $error("result raised without a completed terminator");
`endif

endmodule
